### hw/rtl/jst_pkg.sv
`default_nettype none

package jst_pkg;

  localparam int MAX_DEPTH = 64;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
  localparam int ADDR_W    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int MAG_W     = 64;

  typedef enum logic [2:0] {
    EXP_TOP,
    EXP_KEY_OR_CLOSE,
    EXP_KEY,
    EXP_COLON,
    EXP_VALUE,
    EXP_ELEM_OR_CLOSE,
    EXP_COMMA_OR_CLOSE,
    EXP_DONE
  } gram_t;

  typedef enum logic [1:0] {
    LEX_IDLE,
    LEX_KEY,
    LEX_STR,
    LEX_NUM
  } lex_t;

  typedef enum logic [3:0] {
    EV_NONE,
    EV_OBJ_OPEN,
    EV_OBJ_CLOSE,
    EV_ARR_OPEN,
    EV_ARR_CLOSE,
    EV_KEY_CHAR,
    EV_KEY_END,
    EV_STR_CHAR,
    EV_STR_END,
    EV_NUM_CHAR,
    EV_INT_END,
    EV_DEC_END,
    EV_ERROR
  } event_t;

  typedef enum logic [3:0] {
    ERR_NONE,
    ERR_BAD_CHAR,
    ERR_UNTERM_STR,
    ERR_TWO_DOTS,
    ERR_WANT_COMMA,
    ERR_WANT_KEY,
    ERR_WANT_COLON,
    ERR_WANT_VALUE,
    ERR_BAD_NUMBER,
    ERR_TOO_DEEP
  } err_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    gram_t              gram;
    lex_t               lex;
    logic               neg;
    logic               dot;
    logic               digit;
    logic [MAG_W-1:0]   mag;
    logic               halted;
  } core_state_t;

  typedef struct packed {
    event_t      kind;
    logic [7:0]  ch;
    logic [63:0] val;
    logic [6:0]  depth;
    err_t        err;
    logic        done;
    logic        last;
  } result_t;

  typedef struct packed {
    logic push;
    logic kind;
    logic pop;
  } stack_op_t;

  localparam core_state_t ST_RESET = '{
    depth:  '0,
    gram:   EXP_TOP,
    lex:    LEX_IDLE,
    neg:    1'b0,
    dot:    1'b0,
    digit:  1'b0,
    mag:    '0,
    halted: 1'b0
  };

endpackage

`default_nettype wire

### hw/rtl/jst_ram.sv
`default_nettype none

module jst_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/jst_step.sv
`default_nettype none

module jst_step (
  input  jst_pkg::core_state_t st,
  input  logic                 action,
  input  logic [7:0]           text_byte,
  input  logic                 top_kind,
  output jst_pkg::core_state_t st_next,
  output jst_pkg::result_t     res0,
  output jst_pkg::result_t     res1,
  output logic [1:0]           res_count,
  output jst_pkg::stack_op_t   op
);

  localparam int DW = jst_pkg::DEPTH_W;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  typedef enum logic [3:0] {
    A_NONE,
    A_FAIL,
    A_CLOSE,
    A_OPEN_OBJ,
    A_OPEN_ARR,
    A_STR,
    A_KEY,
    A_NUM,
    A_GRAM
  } act_t;

  typedef struct packed {
    jst_pkg::core_state_t s;
    jst_pkg::result_t     r;
  } single_t;

  typedef struct packed {
    single_t            o;
    logic               emit;
    jst_pkg::stack_op_t op;
  } tok_t;

  function automatic logic is_digit(logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return (b == CH_SPACE) || (b inside {[8'd9:8'd13]});
  endfunction

  function automatic logic is_start(logic [7:0] b);
    return is_digit(b) || (b inside {CH_MINUS, CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK,
                                     CH_COMMA, CH_COLON, CH_QUOTE});
  endfunction

  function automatic jst_pkg::result_t mk_res(jst_pkg::event_t kind, logic [7:0] ch,
                                              logic [63:0] val, jst_pkg::err_t err,
                                              logic done, logic [DW-1:0] depth);
    jst_pkg::result_t r;
    r.kind  = kind;
    r.ch    = ch;
    r.val   = val;
    r.depth = 7'(depth);
    r.err   = err;
    r.done  = done;
    r.last  = 1'b0;
    return r;
  endfunction

  function automatic single_t fail_f(jst_pkg::core_state_t s, jst_pkg::err_t code);
    single_t o;
    o.s        = s;
    o.s.halted = 1'b1;
    o.s.lex    = jst_pkg::LEX_IDLE;
    o.r        = mk_res(jst_pkg::EV_ERROR, 8'd0, 64'd0, code, 1'b0, s.depth);
    return o;
  endfunction

  function automatic single_t vdone_f(jst_pkg::core_state_t s, jst_pkg::event_t kind,
                                      logic [63:0] val);
    single_t o;
    o.s = s;
    if (s.depth == '0) begin
      o.s.halted = 1'b1;
      o.s.gram   = jst_pkg::EXP_DONE;
      o.r        = mk_res(kind, 8'd0, val, jst_pkg::ERR_NONE, 1'b1, s.depth);
    end else begin
      o.s.gram = jst_pkg::EXP_COMMA_OR_CLOSE;
      o.r      = mk_res(kind, 8'd0, val, jst_pkg::ERR_NONE, 1'b0, s.depth);
    end
    return o;
  endfunction

  // Close out a pending number; always gives one event.
  function automatic single_t fin_f(jst_pkg::core_state_t s);
    jst_pkg::core_state_t s1;
    logic [63:0]          limit;
    single_t              o;
    s1     = s;
    s1.lex = jst_pkg::LEX_IDLE;
    limit  = s.neg ? NEG_LIMIT : POS_LIMIT;
    if (!s.digit) begin
      o = fail_f(s1, jst_pkg::ERR_BAD_NUMBER);
    end else if (s.dot) begin
      o = vdone_f(s1, jst_pkg::EV_DEC_END, 64'd0);
    end else if (s.mag > limit) begin
      o = fail_f(s1, jst_pkg::ERR_BAD_NUMBER);
    end else begin
      o = vdone_f(s1, jst_pkg::EV_INT_END, s.neg ? (64'd0 - s.mag) : s.mag);
    end
    return o;
  endfunction

  function automatic jst_pkg::err_t eof_err(jst_pkg::gram_t g);
    jst_pkg::err_t e;
    case (g)
      jst_pkg::EXP_KEY_OR_CLOSE, jst_pkg::EXP_KEY: e = jst_pkg::ERR_WANT_KEY;
      jst_pkg::EXP_COLON:                          e = jst_pkg::ERR_WANT_COLON;
      jst_pkg::EXP_COMMA_OR_CLOSE:                 e = jst_pkg::ERR_WANT_COMMA;
      default:                                     e = jst_pkg::ERR_WANT_VALUE;
    endcase
    return e;
  endfunction

  // Handle a byte that arrives between tokens.
  function automatic tok_t tok_f(jst_pkg::core_state_t s, logic [7:0] b, logic top);
    tok_t                 t;
    act_t                 act;
    jst_pkg::err_t        code;
    jst_pkg::gram_t       g;
    jst_pkg::core_state_t s2;
    logic                 topk;
    logic                 arr;
    t.o.s  = s;
    t.o.r  = '0;
    t.emit = 1'b0;
    t.op   = '0;
    act    = A_NONE;
    code   = jst_pkg::ERR_NONE;
    g      = s.gram;
    s2     = s;
    topk   = (s.depth != '0) && top;
    arr    = 1'b0;

    if (is_space(b)) begin
      act = A_NONE;
    end else if (!is_start(b)) begin
      act  = A_FAIL;
      code = jst_pkg::ERR_BAD_CHAR;
    end else begin
      case (s.gram)
        jst_pkg::EXP_TOP, jst_pkg::EXP_VALUE, jst_pkg::EXP_ELEM_OR_CLOSE: begin
          if (s.gram == jst_pkg::EXP_ELEM_OR_CLOSE && b == CH_RBRACK) begin
            act = A_CLOSE;
          end else if (b == CH_LBRACE) begin
            act = A_OPEN_OBJ;
          end else if (b == CH_LBRACK) begin
            act = A_OPEN_ARR;
          end else if (b == CH_QUOTE) begin
            act = A_STR;
          end else if (is_digit(b) || b == CH_MINUS) begin
            act = A_NUM;
          end else begin
            act  = A_FAIL;
            code = jst_pkg::ERR_WANT_VALUE;
          end
        end
        jst_pkg::EXP_KEY_OR_CLOSE, jst_pkg::EXP_KEY: begin
          if (s.gram == jst_pkg::EXP_KEY_OR_CLOSE && b == CH_RBRACE) begin
            act = A_CLOSE;
          end else if (b == CH_QUOTE) begin
            act = A_KEY;
          end else begin
            act  = A_FAIL;
            code = jst_pkg::ERR_WANT_KEY;
          end
        end
        jst_pkg::EXP_COLON: begin
          if (b == CH_COLON) begin
            act = A_GRAM;
            g   = jst_pkg::EXP_VALUE;
          end else begin
            act  = A_FAIL;
            code = jst_pkg::ERR_WANT_COLON;
          end
        end
        jst_pkg::EXP_COMMA_OR_CLOSE: begin
          if (b == (topk ? CH_RBRACK : CH_RBRACE)) begin
            act = A_CLOSE;
          end else if (b == CH_COMMA) begin
            act = A_GRAM;
            g   = topk ? jst_pkg::EXP_VALUE : jst_pkg::EXP_KEY;
          end else begin
            act  = A_FAIL;
            code = jst_pkg::ERR_WANT_COMMA;
          end
        end
        default: begin
          act = A_NONE;
        end
      endcase
    end

    case (act)
      A_FAIL: begin
        t.o    = fail_f(s, code);
        t.emit = 1'b1;
      end
      A_CLOSE: begin
        if (s.depth != '0) begin
          s2.depth = s.depth - DW'(1);
          t.op.pop = 1'b1;
        end
        t.o    = vdone_f(s2, topk ? jst_pkg::EV_ARR_CLOSE : jst_pkg::EV_OBJ_CLOSE, 64'd0);
        t.emit = 1'b1;
      end
      A_OPEN_OBJ, A_OPEN_ARR: begin
        arr    = (act == A_OPEN_ARR);
        t.emit = 1'b1;
        if (s.depth >= DW'(jst_pkg::MAX_DEPTH)) begin
          t.o = fail_f(s, jst_pkg::ERR_TOO_DEEP);
        end else begin
          s2.depth  = s.depth + DW'(1);
          s2.gram   = arr ? jst_pkg::EXP_ELEM_OR_CLOSE : jst_pkg::EXP_KEY_OR_CLOSE;
          t.o.s     = s2;
          t.o.r     = mk_res(arr ? jst_pkg::EV_ARR_OPEN : jst_pkg::EV_OBJ_OPEN, 8'd0, 64'd0,
                             jst_pkg::ERR_NONE, 1'b0, s2.depth);
          t.op.push = 1'b1;
          t.op.kind = arr;
        end
      end
      A_STR: begin
        t.o.s.lex = jst_pkg::LEX_STR;
      end
      A_KEY: begin
        t.o.s.lex = jst_pkg::LEX_KEY;
      end
      A_NUM: begin
        s2.neg   = (b == CH_MINUS);
        s2.dot   = 1'b0;
        s2.digit = is_digit(b);
        s2.mag   = is_digit(b) ? jst_pkg::MAG_W'(b[3:0]) : '0;
        s2.lex   = jst_pkg::LEX_NUM;
        t.o.s    = s2;
        t.o.r    = mk_res(jst_pkg::EV_NUM_CHAR, b, 64'd0, jst_pkg::ERR_NONE, 1'b0, s.depth);
        t.emit   = 1'b1;
      end
      A_GRAM: begin
        t.o.s.gram = g;
      end
      default: begin
        t.emit = 1'b0;
      end
    endcase
    return t;
  endfunction

  single_t              a;
  single_t              bq;
  tok_t                 t;
  jst_pkg::core_state_t sl;
  jst_pkg::result_t     ra;
  jst_pkg::result_t     rb;
  logic                 ea;
  logic                 eb;
  logic [67:0]          mag_x10;

  always_comb begin
    st_next = st;
    op      = '0;
    a       = '0;
    bq      = '0;
    t       = '0;
    sl      = st;
    ra      = '0;
    rb      = '0;
    ea      = 1'b0;
    eb      = 1'b0;
    mag_x10 = {1'b0, st.mag, 3'b000} + {3'b000, st.mag, 1'b0} + 68'(text_byte[3:0]);

    if (!action) begin
      if (!st.halted) begin
        case (st.lex)
          jst_pkg::LEX_NUM: begin
            if (is_digit(text_byte)) begin
              st_next.digit = 1'b1;
              // saturate once the value leaves 64 bits
              st_next.mag   = (mag_x10[67:64] != 4'd0) ? '1 : mag_x10[63:0];
              ra = mk_res(jst_pkg::EV_NUM_CHAR, text_byte, 64'd0, jst_pkg::ERR_NONE, 1'b0,
                          st.depth);
              ea = 1'b1;
            end else if (text_byte == CH_DOT) begin
              ea = 1'b1;
              if (st.dot) begin
                a       = fail_f(st, jst_pkg::ERR_TWO_DOTS);
                st_next = a.s;
                ra      = a.r;
              end else begin
                st_next.dot = 1'b1;
                ra = mk_res(jst_pkg::EV_NUM_CHAR, text_byte, 64'd0, jst_pkg::ERR_NONE, 1'b0,
                            st.depth);
              end
            end else begin
              // terminator byte: finish the number, then treat it as a new token
              a       = fin_f(st);
              st_next = a.s;
              ra      = a.r;
              ea      = 1'b1;
              if (!a.s.halted) begin
                t       = tok_f(a.s, text_byte, top_kind);
                st_next = t.o.s;
                rb      = t.o.r;
                eb      = t.emit;
                op      = t.op;
              end
            end
          end
          jst_pkg::LEX_KEY, jst_pkg::LEX_STR: begin
            ea = 1'b1;
            if (text_byte == CH_QUOTE) begin
              sl.lex = jst_pkg::LEX_IDLE;
              if (st.lex == jst_pkg::LEX_KEY) begin
                st_next      = sl;
                st_next.gram = jst_pkg::EXP_COLON;
                ra = mk_res(jst_pkg::EV_KEY_END, 8'd0, 64'd0, jst_pkg::ERR_NONE, 1'b0,
                            st.depth);
              end else begin
                a       = vdone_f(sl, jst_pkg::EV_STR_END, 64'd0);
                st_next = a.s;
                ra      = a.r;
              end
            end else begin
              ra = mk_res((st.lex == jst_pkg::LEX_KEY) ? jst_pkg::EV_KEY_CHAR
                                                       : jst_pkg::EV_STR_CHAR,
                          text_byte, 64'd0, jst_pkg::ERR_NONE, 1'b0, st.depth);
            end
          end
          default: begin
            t       = tok_f(st, text_byte, top_kind);
            st_next = t.o.s;
            ra      = t.o.r;
            ea      = t.emit;
            op      = t.op;
          end
        endcase
      end
    end else begin
      if (!st.halted) begin
        ea = 1'b1;
        case (st.lex)
          jst_pkg::LEX_NUM: begin
            a  = fin_f(st);
            ra = a.r;
            if (!a.s.halted) begin
              bq = fail_f(a.s, eof_err(a.s.gram));
              rb = bq.r;
              eb = 1'b1;
            end
          end
          jst_pkg::LEX_KEY, jst_pkg::LEX_STR: begin
            a  = fail_f(st, jst_pkg::ERR_UNTERM_STR);
            ra = a.r;
          end
          default: begin
            a  = fail_f(st, eof_err(st.gram));
            ra = a.r;
          end
        endcase
      end
      // rearm
      st_next = jst_pkg::ST_RESET;
    end

    res0      = ea ? ra : rb;
    res1      = rb;
    res_count = {1'b0, ea} + {1'b0, eb};
    if (ea && eb) begin
      res1.last = 1'b1;
    end else begin
      res0.last = 1'b1;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/jst_outq.sv
`default_nettype none

module jst_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_count,
  input  jst_pkg::result_t push0,
  input  jst_pkg::result_t push1,
  input  logic             ready,
  output logic             valid,
  output jst_pkg::result_t head,
  output logic             space2
);

  localparam int Q_DEPTH = 4;
  localparam int PTR_W   = $clog2(Q_DEPTH);
  localparam int CNT_W   = $clog2(Q_DEPTH + 1);

  jst_pkg::result_t q [Q_DEPTH];
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;
  logic [CNT_W-1:0] cnt;
  logic             pop;

  assign valid  = (cnt != '0);
  assign pop    = valid && ready;
  assign head   = q[rp];
  assign space2 = (cnt <= CNT_W'(Q_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      q[wp] <= push0;
    end
    if (push_count == 2'd2) begin
      q[wp + PTR_W'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      wp  <= wp + PTR_W'(push_count);
      rp  <= rp + PTR_W'(pop);
      cnt <= cnt + CNT_W'(push_count) - CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/json_stream_tokenizer_validator.sv
`default_nettype none

// Channel   Dir  Handshake            Content
// s_*       in   s_tvalid / s_tready  tdata: text_byte; tuser: action
// m_*       out  m_tvalid / m_tready  tdata: event fields; tuser: event_kind; tlast: last
//
// One byte is accepted per cycle while the step stage is not stalled. An input register
// feeds the step logic, which writes zero, one or two events into a four-entry result
// queue, and events are presented from that registered queue. A byte that yields two
// events hands them out as two separate output transfers.
// The step stage fires only while the queue has room for two events, so a stalled
// output side backs up into s_tready. Synchronous reset clears the parser state and the
// queue; the container stack memory is not cleared, as only pushed levels are ever read.
module json_stream_tokenizer_validator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tuser,   // [0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // [7:0] char_out, [71:8] int_value, [78:72] nest_depth,
                                 // [82:79] error_code, [83] doc_complete, [87:84] zero
  output logic [3:0]  m_tuser,   // [3:0] event_kind
  output logic        m_tlast
);

  localparam int DW = jst_pkg::DEPTH_W;
  localparam int AW = jst_pkg::ADDR_W;

  logic                 in_valid;
  logic                 in_action;
  logic [7:0]           in_byte;
  logic                 fire;
  logic                 q_space;

  jst_pkg::core_state_t st;
  jst_pkg::core_state_t st_next;
  jst_pkg::result_t     res0;
  jst_pkg::result_t     res1;
  jst_pkg::result_t     head;
  logic [1:0]           res_count;
  jst_pkg::stack_op_t   op;

  logic                 top_kind;
  logic                 below;
  logic                 ram_rdata;
  logic                 byp;
  logic                 byp_data;
  logic                 ram_we;
  logic [DW-1:0]        depth_nx;
  logic [DW-1:0]        depth_m1;
  logic [DW-1:0]        depth_nx_m2;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr;

  assign fire     = in_valid && q_space;
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_action <= s_tuser;
      in_byte   <= s_tdata;
    end
  end

  jst_step u_step (
    .st        (st),
    .action    (in_action),
    .text_byte (in_byte),
    .top_kind  (top_kind),
    .st_next   (st_next),
    .res0      (res0),
    .res1      (res1),
    .res_count (res_count),
    .op        (op)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= jst_pkg::ST_RESET;
    end else if (fire) begin
      st <= st_next;
    end
  end

  // Top of stack lives in a flop; the RAM holds the levels under it and
  // always reads the level just below the next top.
  assign depth_nx    = fire ? st_next.depth : st.depth;
  assign depth_m1    = st.depth - DW'(1);
  assign depth_nx_m2 = depth_nx - DW'(2);
  assign waddr       = depth_m1[AW-1:0];
  assign raddr       = depth_nx_m2[AW-1:0];
  assign ram_we      = fire && op.push && (st.depth != '0);
  assign below       = byp ? byp_data : ram_rdata;

  jst_ram #(
    .WIDTH (1),
    .DEPTH (jst_pkg::MAX_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (top_kind),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    // forward a level written in the same cycle it is read
    byp      <= ram_we && (waddr == raddr);
    byp_data <= top_kind;
    if (fire && op.push) begin
      top_kind <= op.kind;
    end else if (fire && op.pop) begin
      top_kind <= below;
    end
  end

  jst_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push_count (fire ? res_count : 2'd0),
    .push0      (res0),
    .push1      (res1),
    .ready      (m_tready),
    .valid      (m_tvalid),
    .head       (head),
    .space2     (q_space)
  );

  assign m_tdata = {4'd0, head.done, head.err, head.depth, head.val, head.ch};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

endmodule

`default_nettype wire
